// File: hw/rtl/pqsq_pkg.sv
// Shared types and constants for the priority quantum service queue.
package pqsq_pkg;

  localparam int TICKET_W  = 21;
  localparam int URGENCY_W = 8;
  localparam int OPS_W     = 10;
  localparam int QUANTUM_W = 4;
  localparam int STATUS_W  = 3;

  // Reset value of the service quantum register.
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 4'd3;

  // One held entry of the queue.
  typedef struct packed {
    logic [TICKET_W-1:0]  ticket;
    logic [URGENCY_W-1:0] urgency;
    logic [OPS_W-1:0]     pending;
    logic [OPS_W-1:0]     done;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REQUEUE,
    CMD_RETIRE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [URGENCY_W-1:0] key;
    entry_t               fresh;
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_REQUEUED = 3'd3,
    ST_FINISHED = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

endpackage

// File: hw/rtl/pqsq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module pqsq_cell import pqsq_pkg::*; (
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   head,
  input  logic   occ,
  input  entry_t left_entry,
  input  logic   left_le,
  input  entry_t right_entry,
  input  logic   right_le,
  output entry_t entry,
  output logic   le
);

  entry_t entry_next;

  // The slot holds an entry that goes ahead of the key.
  assign le = occ && (entry.urgency <= cmd.key);

  // Insert keeps entries ahead of the key and shifts the rest one slot back.
  // Requeue first drops the head, so every slot looks one place to its right.
  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CMD_INSERT: begin
        if (le) begin
          entry_next = entry;
        end else if (head || left_le) begin
          entry_next = cmd.fresh;
        end else begin
          entry_next = left_entry;
        end
      end
      CMD_REQUEUE: begin
        if (right_le) begin
          entry_next = right_entry;
        end else if (head || le) begin
          entry_next = cmd.fresh;
        end else begin
          entry_next = entry;
        end
      end
      CMD_RETIRE: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: hw/rtl/priority_quantum_service_queue.sv
// Top level of the priority quantum service queue.
//
// A bounded queue kept sorted by ascending urgency, first come first served
// among equal urgency, built as a chain of QUEUE_DEPTH slots. Each request
// is an enqueue (mode 0) or a serve of the head entry (mode 1). The block
// takes one request per clock while in_stall is low: when it takes one, every
// slot compares its urgency with the broadcast key and either keeps its entry,
// takes the new or requeued entry, or takes a neighbor's entry. The serve path
// through the head slot's quantum subtract and that compare sets the cycle.
// The result appears in the output register in the cycle after the request
// and is held there while out_stall is high; a new request is taken in the same
// cycle as the previous result leaves. The service quantum register is at
// byte address 0 and may only be written while the block is idle.
module priority_quantum_service_queue import pqsq_pkg::*; #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int TICKET_MODULUS = 1757600,
  localparam int CountW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [URGENCY_W-1:0] urgency,
  input  logic [OPS_W-1:0]     ops_requested,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [TICKET_W-1:0]  ticket,
  output logic [QUANTUM_W-1:0] ops_served_now,
  output logic [OPS_W-1:0]     ops_remaining,
  output logic [OPS_W-1:0]     ops_done_total,
  output logic [CountW-1:0]    occupancy,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [CountW-1:0]   DepthCount = CountW'(QUEUE_DEPTH);
  localparam logic [TICKET_W-1:0] TicketLast = TICKET_W'(TICKET_MODULUS - 1);

  logic [QUANTUM_W-1:0] quantum;
  logic [CountW-1:0]    count;
  logic [CountW-1:0]    count_next;
  logic [TICKET_W-1:0]  ticket_ctr;
  logic [TICKET_W-1:0]  ticket_ctr_next;

  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_le;
  logic [QUEUE_DEPTH-1:0] occ;
  cmd_t                   cmd;

  logic                 accept;
  logic [QUANTUM_W-1:0] q_eff;
  logic                 more_work;
  entry_t               head_entry;
  entry_t               served;

  status_t              res_status;
  logic [TICKET_W-1:0]  res_ticket;
  logic [QUANTUM_W-1:0] res_now;
  logic [OPS_W-1:0]     res_rem;
  logic [OPS_W-1:0]     res_done;

  status_t              status_reg;

  // Configuration register access.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - QUANTUM_W){1'b0}}, quantum} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      quantum <= pwdata[QUANTUM_W-1:0];
    end
  end

  // A request is taken whenever the output register is free or draining.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Slot occupancy follows from the entry count.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_occ
    assign occ[i] = (count > CountW'(i));
  end

  // Head slot work for a serve.
  assign head_entry = cell_entry[0];
  assign q_eff      = (quantum == '0) ? QUANTUM_W'(1) : quantum;
  assign more_work  = head_entry.pending > OPS_W'(q_eff);

  always_comb begin
    served = head_entry;
    if (more_work) begin
      served.pending = head_entry.pending - OPS_W'(q_eff);
      served.done    = head_entry.done + OPS_W'(q_eff);
    end else begin
      served.pending = '0;
      served.done    = head_entry.done + head_entry.pending;
    end
  end

  // Decode the request into a chain command and a result.
  always_comb begin
    cmd.op          = CMD_HOLD;
    cmd.key         = urgency;
    cmd.fresh       = '{ticket: ticket_ctr, urgency: urgency,
                        pending: ops_requested, done: '0};
    count_next      = count;
    ticket_ctr_next = ticket_ctr;
    res_status      = ST_EMPTY;
    res_ticket      = '0;
    res_now         = '0;
    res_rem         = '0;
    res_done        = '0;
    if (mode == 1'b0) begin
      if ((urgency == '0) || (ops_requested == '0)) begin
        res_status = ST_INVALID;
      end else if (count == DepthCount) begin
        res_status = ST_FULL;
      end else begin
        res_status      = ST_ENQUEUED;
        res_ticket      = ticket_ctr;
        res_rem         = ops_requested;
        cmd.op          = CMD_INSERT;
        count_next      = count + CountW'(1);
        ticket_ctr_next = (ticket_ctr == TicketLast) ? '0 : ticket_ctr + TICKET_W'(1);
      end
    end else if (count != '0) begin
      res_ticket = head_entry.ticket;
      res_rem    = served.pending;
      res_done   = served.done;
      cmd.key    = head_entry.urgency;
      cmd.fresh  = served;
      if (more_work) begin
        res_status = ST_REQUEUED;
        res_now    = q_eff;
        cmd.op     = CMD_REQUEUE;
      end else begin
        res_status = ST_FINISHED;
        res_now    = head_entry.pending[QUANTUM_W-1:0];
        cmd.op     = CMD_RETIRE;
        count_next = count - CountW'(1);
      end
    end
    if (!accept) begin
      cmd.op          = CMD_HOLD;
      count_next      = count;
      ticket_ctr_next = ticket_ctr;
    end
  end

  // Chain of slots.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    logic   left_le;
    entry_t right_entry;
    logic   right_le;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_le    = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
      assign right_le    = 1'b0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
      assign right_le    = cell_le[i+1];
    end

    pqsq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .head        (i == 0),
      .occ         (occ[i]),
      .left_entry  (left_entry),
      .left_le     (left_le),
      .right_entry (right_entry),
      .right_le    (right_le),
      .entry       (cell_entry[i]),
      .le          (cell_le[i])
    );
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ticket_ctr <= '0;
      out_valid  <= 1'b0;
    end else begin
      count      <= count_next;
      ticket_ctr <= ticket_ctr_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_reg     <= res_status;
      ticket         <= res_ticket;
      ops_served_now <= res_now;
      ops_remaining  <= res_rem;
      ops_done_total <= res_done;
      occupancy      <= count_next;
    end
  end

  assign status = status_reg;

`ifndef SYNTHESIS
  // The entry count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthCount)
    else $error("entry count exceeds queue depth");

  // An insert grows the queue by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_INSERT) |=> (count == $past(count) + CountW'(1)))
    else $error("insert did not grow the queue by one");

  // The reported occupancy matches the count it was taken from.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (occupancy == count))
    else $error("reported occupancy differs from entry count");

  // A finished serve leaves no pending work.
  a_finished_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status_reg == ST_FINISHED)) |-> (ops_remaining == '0))
    else $error("finished serve reports remaining work");

  // Held entries stay sorted by urgency.
  for (genvar i = 0; i < QUEUE_DEPTH - 1; i++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      occ[i+1] |-> (cell_entry[i].urgency <= cell_entry[i+1].urgency))
      else $error("queue order broken");
  end
`endif

endmodule
